// ----- design/urs_pkg.sv -----
// shared types, constants and tables of the ultrasonic ranger core
package urs_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_DIGITS     = 4;
    localparam int QUEUE_DEPTH    = 4;

    localparam int TRIG_BITS      = 8;
    localparam int DISP_BITS      = 24;
    localparam int DWELL_BITS     = 16;
    localparam int SCALE_BITS     = 16;
    localparam int DIST_BITS      = 11;
    localparam int SEL_BITS       = 2;
    localparam int SEG_BITS       = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int KIND_BITS      = 2;

    localparam logic [DIST_BITS-1:0] DIST_MAX     = 11'd2047;
    localparam logic [SEG_BITS-1:0]  IDLE_PATTERN = 8'hF9;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISPLAY = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DWELL   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE   = 3'd3;

    localparam logic [TRIG_BITS-1:0]  RST_TRIGGER = 8'd10;
    localparam logic [DISP_BITS-1:0]  RST_DISPLAY = 24'd300000;
    localparam logic [DWELL_BITS-1:0] RST_DWELL   = 16'd250;
    localparam logic [SCALE_BITS-1:0] RST_SCALE   = 16'd1124;

    typedef enum logic [1:0] {
        PH_TRIGGER,
        PH_WAIT,
        PH_COUNT,
        PH_DISPLAY
    } t_phase;

    // what the back end has to do with one tick
    typedef enum logic [KIND_BITS-1:0] {
        K_IDLE,
        K_TRIG,
        K_MEAS,
        K_SHOW
    } t_kind;

    typedef struct packed {
        logic [TRIG_BITS-1:0]  trigger_ticks;
        logic [DISP_BITS-1:0]  display_ticks;
        logic [DWELL_BITS-1:0] dwell_ticks;
    } t_timing;

    typedef logic [3:0] t_digit;

    function automatic int idx_bits(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic logic [SEG_BITS-1:0] seg_pattern(t_digit d);
        logic [SEG_BITS-1:0] p;
        case (d)
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            4'd9:    p = 8'h6f;
            default: p = 8'h3f;
        endcase
        return p;
    endfunction

endpackage

// ----- design/urs_front.sv -----
// front end: phase sequencer that classifies each tick for the back end
module urs_front #(
    parameter int COUNT_BITS = urs_pkg::DEF_COUNT_BITS,
    parameter int DIGITS     = urs_pkg::DEF_DIGITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  urs_pkg::t_timing                      i_timing,
    input  logic                                  i_push,
    input  logic                                  i_echo,
    input  logic                                  i_q_full,
    output logic                                  o_q_push,
    output urs_pkg::t_kind                        o_kind,
    output logic [urs_pkg::idx_bits(DIGITS)-1:0]  o_idx,
    output logic [COUNT_BITS-1:0]                 o_count
);
    import urs_pkg::*;

    localparam int IDX_BITS = idx_bits(DIGITS);

    t_phase                r_phase, n_phase;
    logic [DISP_BITS-1:0]  r_phase_timer, n_phase_timer;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [IDX_BITS-1:0]   r_digit_idx, n_digit_idx;
    logic [DWELL_BITS-1:0] r_dwell, n_dwell;

    logic [DISP_BITS-1:0]  w_phase_inc;
    logic [DWELL_BITS-1:0] w_dwell_inc;
    logic                  w_accept;

    assign w_accept    = i_push && !i_q_full;
    assign w_phase_inc = r_phase_timer + DISP_BITS'(1);
    assign w_dwell_inc = r_dwell + DWELL_BITS'(1);
    assign o_q_push    = w_accept;

    always_comb begin
        n_phase       = r_phase;
        n_phase_timer = r_phase_timer;
        n_count       = r_count;
        n_digit_idx   = r_digit_idx;
        n_dwell       = r_dwell;
        unique case (r_phase)
            PH_TRIGGER: begin
                n_phase_timer = w_phase_inc;
                if (w_phase_inc >= DISP_BITS'(i_timing.trigger_ticks)) begin
                    n_phase       = PH_WAIT;
                    n_phase_timer = '0;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_count = COUNT_BITS'(1);
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo) begin
                    if (r_count != '1) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                end else begin
                    n_digit_idx   = '0;
                    n_dwell       = '0;
                    n_phase_timer = '0;
                    n_phase       = PH_DISPLAY;
                end
            end
            PH_DISPLAY: begin
                n_dwell = w_dwell_inc;
                if (w_dwell_inc >= i_timing.dwell_ticks) begin
                    n_dwell     = '0;
                    n_digit_idx = (r_digit_idx == IDX_BITS'(DIGITS - 1)) ? '0
                                : r_digit_idx + IDX_BITS'(1);
                end
                n_phase_timer = w_phase_inc;
                if (w_phase_inc >= i_timing.display_ticks) begin
                    n_phase_timer = '0;
                    n_phase       = PH_TRIGGER;
                end
            end
        endcase
    end

    always_comb begin
        o_idx   = r_digit_idx;
        o_count = r_count;
        unique case (r_phase)
            PH_TRIGGER: o_kind = K_TRIG;
            PH_WAIT:    o_kind = K_IDLE;
            PH_COUNT:   o_kind = i_echo ? K_IDLE : K_MEAS;
            PH_DISPLAY: o_kind = K_SHOW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TRIGGER;
            r_phase_timer <= '0;
            r_count       <= '0;
            r_digit_idx   <= '0;
            r_dwell       <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_phase_timer <= n_phase_timer;
            r_count       <= n_count;
            r_digit_idx   <= n_digit_idx;
            r_dwell       <= n_dwell;
        end
    end

endmodule

// ----- design/urs_queue.sv -----
// short register queue between the front and back ends
module urs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = urs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import urs_pkg::*;

    localparam int PTR_BITS = idx_bits(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_wr, w_rd;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/urs_back.sv -----
// back end: distance pipeline, decimal digits, segment drive and result register
module urs_back #(
    parameter int COUNT_BITS = urs_pkg::DEF_COUNT_BITS,
    parameter int DIGITS     = urs_pkg::DEF_DIGITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [urs_pkg::SCALE_BITS-1:0]        i_scale,
    input  logic                                  i_q_empty,
    output logic                                  o_q_pop,
    input  urs_pkg::t_kind                        i_kind,
    input  logic [urs_pkg::idx_bits(DIGITS)-1:0]  i_idx,
    input  logic [COUNT_BITS-1:0]                 i_count,
    input  logic                                  i_pop,
    output logic                                  o_empty,
    output logic                                  o_trigger_out,
    output logic [urs_pkg::SEL_BITS-1:0]          o_digit_select,
    output logic [urs_pkg::SEG_BITS-1:0]          o_segments,
    output logic [urs_pkg::DIST_BITS-1:0]         o_distance_cm,
    output logic                                  o_distance_new
);
    import urs_pkg::*;

    localparam int IDX_BITS   = idx_bits(DIGITS);
    localparam int PROD_BITS  = COUNT_BITS + SCALE_BITS;
    localparam int SHIFT_BITS = PROD_BITS - 15;
    localparam int RMUL_BITS  = DIST_BITS + 14;
    localparam int QUOT_BITS  = RMUL_BITS - 16;
    localparam int LAST       = DIGITS - 1;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(32'h7FFF);
    localparam logic [13:0]        RECIP_10   = 14'd6554;

    logic                  w_adv;

    // multiply stage
    logic                  r_s0_vld;
    t_kind                 r_s0_kind;
    logic [IDX_BITS-1:0]   r_s0_idx;
    logic [PROD_BITS-1:0]  r_s0_prod;
    logic [PROD_BITS-1:0]  w_prod;

    // round and clamp stage
    logic                  r_s1_vld;
    t_kind                 r_s1_kind;
    logic [IDX_BITS-1:0]   r_s1_idx;
    logic [DIST_BITS-1:0]  r_s1_dist;
    logic [PROD_BITS:0]    w_round;
    logic [SHIFT_BITS-1:0] w_shifted;
    logic [DIST_BITS-1:0]  w_dist;

    // one decimal digit per stage
    logic                  r_dg_vld  [DIGITS];
    t_kind                 r_dg_kind [DIGITS];
    logic [IDX_BITS-1:0]   r_dg_idx  [DIGITS];
    logic [DIST_BITS-1:0]  r_dg_dist [DIGITS];
    logic [DIST_BITS-1:0]  r_dg_rem  [DIGITS];
    t_digit                r_dg_val  [DIGITS][DIGITS];

    logic                  w_in_vld  [DIGITS];
    t_kind                 w_in_kind [DIGITS];
    logic [IDX_BITS-1:0]   w_in_idx  [DIGITS];
    logic [DIST_BITS-1:0]  w_in_dist [DIGITS];
    logic [DIST_BITS-1:0]  w_in_rem  [DIGITS];
    t_digit                w_in_val  [DIGITS][DIGITS];
    logic [RMUL_BITS-1:0]  w_rmul    [DIGITS];
    logic [QUOT_BITS-1:0]  w_quot    [DIGITS];
    logic [DIST_BITS-1:0]  n_dg_rem  [DIGITS];
    t_digit                n_dg_val  [DIGITS][DIGITS];

    // readout state and result register
    logic [DIST_BITS-1:0]  r_last_dist;
    t_digit                r_digit_vals [DIGITS];
    logic                  r_out_vld;
    logic                  r_out_trig;
    logic [SEL_BITS-1:0]   r_out_sel;
    logic [SEG_BITS-1:0]   r_out_seg;
    logic [DIST_BITS-1:0]  r_out_dist;
    logic                  r_out_new;
    logic                  w_o_trig;
    logic [SEL_BITS-1:0]   w_o_sel;
    logic [SEG_BITS-1:0]   w_o_seg;
    logic [DIST_BITS-1:0]  w_o_dist;
    logic                  w_o_new;
    logic                  w_meas_done;

    assign w_adv   = !r_out_vld || i_pop;
    assign o_q_pop = w_adv && !i_q_empty;
    assign o_empty = !r_out_vld;

    assign w_prod    = {{SCALE_BITS{1'b0}}, i_count} * {{COUNT_BITS{1'b0}}, i_scale};
    assign w_round   = {1'b0, r_s0_prod} + ROUND_HALF;
    assign w_shifted = w_round[PROD_BITS:16];
    assign w_dist    = (w_shifted > SHIFT_BITS'(DIST_MAX)) ? DIST_MAX
                     : w_shifted[DIST_BITS-1:0];

    always_comb begin
        w_in_vld[0]  = r_s1_vld;
        w_in_kind[0] = r_s1_kind;
        w_in_idx[0]  = r_s1_idx;
        w_in_dist[0] = r_s1_dist;
        w_in_rem[0]  = r_s1_dist;
        for (int k = 0; k < DIGITS; k++) begin
            w_in_val[0][k] = '0;
        end
        for (int j = 1; j < DIGITS; j++) begin
            w_in_vld[j]  = r_dg_vld[j-1];
            w_in_kind[j] = r_dg_kind[j-1];
            w_in_idx[j]  = r_dg_idx[j-1];
            w_in_dist[j] = r_dg_dist[j-1];
            w_in_rem[j]  = r_dg_rem[j-1];
            w_in_val[j]  = r_dg_val[j-1];
        end
        for (int j = 0; j < DIGITS; j++) begin
            w_rmul[j]      = RMUL_BITS'(w_in_rem[j]) * RMUL_BITS'(RECIP_10);
            w_quot[j]      = w_rmul[j][RMUL_BITS-1:16];
            n_dg_rem[j]    = DIST_BITS'(w_quot[j]);
            n_dg_val[j]    = w_in_val[j];
            n_dg_val[j][j] = t_digit'(w_in_rem[j] - DIST_BITS'(w_quot[j]) * DIST_BITS'(10));
        end
    end

    assign w_meas_done = r_dg_vld[LAST] && (r_dg_kind[LAST] == K_MEAS);

    always_comb begin
        w_o_trig = 1'b0;
        w_o_sel  = '0;
        w_o_seg  = IDLE_PATTERN;
        w_o_dist = r_last_dist;
        w_o_new  = 1'b0;
        unique case (r_dg_kind[LAST])
            K_IDLE: begin
            end
            K_TRIG: begin
                w_o_trig = 1'b1;
            end
            K_MEAS: begin
                w_o_dist = r_dg_dist[LAST];
                w_o_new  = 1'b1;
            end
            K_SHOW: begin
                w_o_sel = SEL_BITS'({2'b00, r_dg_idx[LAST]});
                w_o_seg = seg_pattern(r_digit_vals[r_dg_idx[LAST]]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld    <= 1'b0;
            r_s0_kind   <= K_IDLE;
            r_s1_vld    <= 1'b0;
            r_s1_kind   <= K_IDLE;
            for (int j = 0; j < DIGITS; j++) begin
                r_dg_vld[j]     <= 1'b0;
                r_dg_kind[j]    <= K_IDLE;
                r_digit_vals[j] <= '0;
            end
            r_out_vld   <= 1'b0;
            r_last_dist <= '0;
        end else if (w_adv) begin
            r_s0_vld  <= o_q_pop;
            r_s0_kind <= o_q_pop ? i_kind : K_IDLE;
            r_s1_vld  <= r_s0_vld;
            r_s1_kind <= r_s0_kind;
            for (int j = 0; j < DIGITS; j++) begin
                r_dg_vld[j]  <= w_in_vld[j];
                r_dg_kind[j] <= w_in_kind[j];
            end
            r_out_vld <= r_dg_vld[LAST];
            if (w_meas_done) begin
                r_last_dist  <= r_dg_dist[LAST];
                r_digit_vals <= r_dg_val[LAST];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_idx  <= i_idx;
            r_s0_prod <= w_prod;
            r_s1_idx  <= r_s0_idx;
            r_s1_dist <= w_dist;
            for (int j = 0; j < DIGITS; j++) begin
                r_dg_idx[j]  <= w_in_idx[j];
                r_dg_dist[j] <= w_in_dist[j];
                r_dg_rem[j]  <= n_dg_rem[j];
                r_dg_val[j]  <= n_dg_val[j];
            end
            r_out_trig <= w_o_trig;
            r_out_sel  <= w_o_sel;
            r_out_seg  <= w_o_seg;
            r_out_dist <= w_o_dist;
            r_out_new  <= w_o_new;
        end
    end

    assign o_trigger_out  = r_out_trig;
    assign o_digit_select = r_out_sel;
    assign o_segments     = r_out_seg;
    assign o_distance_cm  = r_out_dist;
    assign o_distance_new = r_out_new;

endmodule

// ----- design/ultrasonic_ranger_seven_segment_core.sv -----
// top level of the ultrasonic ranger with multiplexed seven-segment readout
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------
//  tick in   | push / full             | i_echo_level
//  result    | empty / pop             | o_trigger_out o_digit_select o_segments
//            |                         | o_distance_cm o_distance_new
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
//  one tick per cycle in while full is low, one result per cycle out while pop is
//  held high; the front end phase sequencer classifies each tick combinationally
//  a tick passes the queue, multiply, round and digit stages and the result register
//  synchronous reset, no clearing pass; config registers return to their defaults
//  pop and empty both low freeze the back end; the 4-entry queue fills, full rises
module ultrasonic_ranger_seven_segment_core #(
    parameter int COUNT_BITS = urs_pkg::DEF_COUNT_BITS,
    parameter int DIGITS     = urs_pkg::DEF_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_echo_level,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_trigger_out,
    output logic [urs_pkg::SEL_BITS-1:0]        o_digit_select,
    output logic [urs_pkg::SEG_BITS-1:0]        o_segments,
    output logic [urs_pkg::DIST_BITS-1:0]       o_distance_cm,
    output logic                                o_distance_new,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [urs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [urs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import urs_pkg::*;

    localparam int IDX_BITS = idx_bits(DIGITS);
    localparam int Q_WIDTH  = KIND_BITS + IDX_BITS + COUNT_BITS;

    logic [TRIG_BITS-1:0]  r_trigger_ticks;
    logic [DISP_BITS-1:0]  r_display_ticks;
    logic [DWELL_BITS-1:0] r_dwell_ticks;
    logic [SCALE_BITS-1:0] r_scale;
    t_timing               w_timing;
    logic                  w_cfg_wr;

    logic                  w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_kind                 w_f_kind;
    logic [IDX_BITS-1:0]   w_f_idx;
    logic [COUNT_BITS-1:0] w_f_count;
    logic [Q_WIDTH-1:0]    w_q_wdata, w_q_rdata;
    t_kind                 w_b_kind;
    logic [IDX_BITS-1:0]   w_b_idx;
    logic [COUNT_BITS-1:0] w_b_count;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= RST_TRIGGER;
            r_display_ticks <= RST_DISPLAY;
            r_dwell_ticks   <= RST_DWELL;
            r_scale         <= RST_SCALE;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_TRIGGER: r_trigger_ticks <= i_cfg_data[TRIG_BITS-1:0];
                CFG_DISPLAY: r_display_ticks <= i_cfg_data[DISP_BITS-1:0];
                CFG_DWELL:   r_dwell_ticks   <= i_cfg_data[DWELL_BITS-1:0];
                CFG_SCALE:   r_scale         <= i_cfg_data[SCALE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_timing.trigger_ticks = r_trigger_ticks;
    assign w_timing.display_ticks = r_display_ticks;
    assign w_timing.dwell_ticks   = r_dwell_ticks;

    urs_front #(
        .COUNT_BITS (COUNT_BITS),
        .DIGITS     (DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_timing (w_timing),
        .i_push   (push),
        .i_echo   (i_echo_level),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_kind   (w_f_kind),
        .o_idx    (w_f_idx),
        .o_count  (w_f_count)
    );

    assign full      = w_q_full;
    assign w_q_wdata = {w_f_kind, w_f_idx, w_f_count};

    urs_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    assign w_b_kind  = t_kind'(w_q_rdata[Q_WIDTH-1 -: KIND_BITS]);
    assign w_b_idx   = w_q_rdata[COUNT_BITS +: IDX_BITS];
    assign w_b_count = w_q_rdata[COUNT_BITS-1:0];

    urs_back #(
        .COUNT_BITS (COUNT_BITS),
        .DIGITS     (DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scale        (r_scale),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .i_kind         (w_b_kind),
        .i_idx          (w_b_idx),
        .i_count        (w_b_count),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_trigger_out  (o_trigger_out),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_distance_cm  (o_distance_cm),
        .o_distance_new (o_distance_new)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("queue reports full and empty together");

    a_new_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_distance_new) |->
        (o_segments == IDLE_PATTERN && o_digit_select == 2'b00 && !o_trigger_out))
        else $error("fresh distance result is not shown blank");

    a_trig_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_trigger_out) |->
        (o_segments == IDLE_PATTERN && !o_distance_new))
        else $error("trigger result drives the display");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present straight after reset");

endmodule

// ----- tb/tb_ultrasonic_ranger_seven_segment_core.sv -----
// self-checking testbench of the ultrasonic ranger core, with its own predictor of each tick
module tb_ultrasonic_ranger_seven_segment_core;
    timeunit 1ns;
    timeprecision 1ps;

    import urs_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = DEF_DIGITS + 8;
    localparam int RANDOM_TICKS  = 100;

    localparam logic [SEG_BITS-1:0] DIGIT_GLYPH [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic                 trig;
        logic [SEL_BITS-1:0]  sel;
        logic [SEG_BITS-1:0]  seg;
        logic [DIST_BITS-1:0] distance;
        logic                 fresh;
    } t_reading;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      push         = 1'b0;
    logic                      pop          = 1'b0;
    logic                      i_echo_level = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index  = CFG_TRIGGER;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data   = '0;
    logic                      full;
    logic                      empty;
    logic                      o_trigger_out;
    logic [SEL_BITS-1:0]       o_digit_select;
    logic [SEG_BITS-1:0]       o_segments;
    logic [DIST_BITS-1:0]      o_distance_cm;
    logic                      o_distance_new;
    logic                      o_cfg_ready;

    t_reading readings_q[$];
    t_reading head;
    int       mismatches   = 0;
    int       ticks_sent   = 0;
    int       stall_cycles = 0;
    bit       offering     = 1'b0;
    bit       cfg_offering = 1'b0;
    bit       tx_gaps      = 1'b1;
    bit       rx_gaps      = 1'b1;
    bit       hold_rx      = 1'b0;

    // predictor copy of the configuration and state
    logic [TRIG_BITS-1:0]      cfg_trigger;
    logic [DISP_BITS-1:0]      cfg_display;
    logic [DWELL_BITS-1:0]     cfg_dwell;
    logic [SCALE_BITS-1:0]     cfg_scale;
    t_phase                    rng_phase;
    logic [DISP_BITS-1:0]      rng_timer;
    logic [DEF_COUNT_BITS-1:0] rng_count;
    t_digit                    rng_digits [DEF_DIGITS];
    logic [SEL_BITS-1:0]       rng_sel;
    logic [DWELL_BITS-1:0]     rng_dwell;
    logic [DIST_BITS-1:0]      rng_dist;

    ultrasonic_ranger_seven_segment_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_echo_level   (i_echo_level),
        .empty          (empty),
        .pop            (pop),
        .o_trigger_out  (o_trigger_out),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_distance_cm  (o_distance_cm),
        .o_distance_new (o_distance_new),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void ranger_reset();
        cfg_trigger = RST_TRIGGER;
        cfg_display = RST_DISPLAY;
        cfg_dwell   = RST_DWELL;
        cfg_scale   = RST_SCALE;
        rng_phase   = PH_TRIGGER;
        rng_timer   = '0;
        rng_count   = '0;
        foreach (rng_digits[k]) rng_digits[k] = '0;
        rng_sel     = '0;
        rng_dwell   = '0;
        rng_dist    = '0;
    endfunction

    function automatic t_reading ranger_tick(input logic echo);
        t_reading                            r;
        logic [DEF_COUNT_BITS+SCALE_BITS:0]  prod;
        int                                  rem;
        r.trig  = 1'b0;
        r.sel   = '0;
        r.seg   = IDLE_PATTERN;
        r.fresh = 1'b0;
        case (rng_phase)
            PH_TRIGGER: begin
                r.trig    = 1'b1;
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= cfg_trigger) begin
                    rng_phase = PH_WAIT;
                    rng_timer = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    rng_count = DEF_COUNT_BITS'(1);
                    rng_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    if (rng_count != '1) rng_count = rng_count + 1'b1;
                end else begin
                    // round to nearest, an exact half rounds down
                    prod = {1'b0, rng_count} * cfg_scale + 'h7FFF;
                    if (prod[DEF_COUNT_BITS+SCALE_BITS:SCALE_BITS] > DIST_MAX)
                        rng_dist = DIST_MAX;
                    else
                        rng_dist = prod[SCALE_BITS +: DIST_BITS];
                    rem = rng_dist;
                    foreach (rng_digits[k]) begin
                        rng_digits[k] = t_digit'(rem % 10);
                        rem = rem / 10;
                    end
                    r.fresh   = 1'b1;
                    rng_sel   = '0;
                    rng_dwell = '0;
                    rng_timer = '0;
                    rng_phase = PH_DISPLAY;
                end
            end
            PH_DISPLAY: begin
                r.sel     = rng_sel;
                r.seg     = DIGIT_GLYPH[rng_digits[rng_sel]];
                rng_dwell = rng_dwell + 1'b1;
                if (rng_dwell >= cfg_dwell) begin
                    rng_dwell = '0;
                    rng_sel   = rng_sel + 1'b1;
                end
                rng_timer = rng_timer + 1'b1;
                if (rng_timer >= cfg_display) begin
                    rng_timer = '0;
                    rng_phase = PH_TRIGGER;
                end
            end
        endcase
        r.distance = rng_dist;
        return r;
    endfunction

    task automatic stop_offering();
        if (offering) begin
            push <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_tick(input logic echo);
        if (cfg_offering) begin
            i_cfg_valid <= 1'b0;
            cfg_offering = 1'b0;
        end
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            stop_offering();
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        if (!offering) begin
            push <= 1'b1;
            offering = 1'b1;
        end
        i_echo_level <= echo;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        readings_q.push_back(ranger_tick(echo));
        ticks_sent++;
    endtask

    task automatic wait_drain();
        stop_offering();
        while (readings_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_drain();
        i_cfg_valid <= 1'b1;
        cfg_offering = 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TRIGGER: cfg_trigger = data[TRIG_BITS-1:0];
            CFG_DISPLAY: cfg_display = data[DISP_BITS-1:0];
            CFG_DWELL:   cfg_dwell   = data[DWELL_BITS-1:0];
            CFG_SCALE:   cfg_scale   = data[SCALE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_random_reg();
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        idx  = CFG_INDEX_BITS'($urandom_range(0, 7));
        data = CFG_DATA_BITS'($urandom());
        case (idx)
            CFG_TRIGGER: data[TRIG_BITS-1:0] = TRIG_BITS'($urandom_range(0, 12));
            CFG_DISPLAY: data = CFG_DATA_BITS'($urandom_range(0, 24));
            CFG_DWELL:   data = CFG_DATA_BITS'($urandom_range(0, 8));
            default: ;
        endcase
        write_reg(idx, data);
    endtask

    // one full trigger, echo and display sequence, starting from wherever the block is
    task automatic ranging_cycle(input int wait_len, input int count);
        while (rng_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
        repeat (wait_len) send_tick(1'b0);
        repeat (count) send_tick(1'b1);
        send_tick(1'b0);
        while (rng_phase == PH_DISPLAY) send_tick(1'($urandom_range(0, 1)));
    endtask

    task automatic test_reset_defaults();
        while (rng_phase != PH_WAIT) send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        repeat (30) send_tick(1'b1);
        send_tick(1'b0);
        repeat (10) send_tick(1'($urandom_range(0, 1)));
        // timers are compared with >=, so a change mid display acts at once
        write_reg(CFG_DISPLAY, '1);
        write_reg(CFG_DWELL, '1);
        repeat (5) send_tick(1'($urandom_range(0, 1)));
        write_reg(CFG_DISPLAY, 24'd30);
        write_reg(CFG_DWELL, 24'd2);
        while (rng_phase == PH_DISPLAY) send_tick(1'($urandom_range(0, 1)));
    endtask

    task automatic test_zero_registers();
        write_reg(CFG_TRIGGER, 24'd0);
        write_reg(CFG_DISPLAY, 24'd0);
        write_reg(CFG_DWELL, 24'd0);
        write_reg(CFG_SCALE, 24'd0);
        ranging_cycle(0, 5);
        write_reg(CFG_SCALE, 24'd65535);
        write_reg(CFG_DISPLAY, 24'd8);
        ranging_cycle(1, 30);
    endtask

    task automatic test_extremes();
        write_reg(CFG_TRIGGER, 24'hFFFF03);
        write_reg(CFG_DISPLAY, 24'd1);
        write_reg(CFG_DWELL, '1);
        write_reg(CFG_SCALE, '1);
        ranging_cycle(2, 20);
        // all four digits shown in turn
        write_reg(CFG_TRIGGER, 24'hFFFF01);
        write_reg(CFG_DWELL, 24'd1);
        write_reg(CFG_DISPLAY, 24'd8);
        ranging_cycle(0, 15);
    endtask

    task automatic test_rounding();
        write_reg(CFG_TRIGGER, 24'd1);
        write_reg(CFG_DISPLAY, 24'd2);
        write_reg(CFG_DWELL, 24'd1);
        write_reg(CFG_SCALE, 24'h008000);
        ranging_cycle(0, 1);
        ranging_cycle(0, 3);
        write_reg(CFG_SCALE, 24'h008001);
        ranging_cycle(0, 1);
        write_reg(CFG_SCALE, 24'h007FFF);
        ranging_cycle(1, 1);
    endtask

    task automatic test_unknown_index();
        write_reg(CFG_SCALE, 24'h008001);
        for (int i = 1; i <= 4; i++) begin
            write_reg(CFG_INDEX_BITS'(int'(CFG_SCALE) + i), '1);
            write_reg(CFG_INDEX_BITS'(int'(CFG_SCALE) + i), 24'($urandom()));
        end
        ranging_cycle(1, 20);
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_DISPLAY, 24'd12);
        write_reg(CFG_DWELL, 24'd3);
        tx_gaps = 1'b0;
        hold_rx = 1'b1;
        ranging_cycle(2, 24);
        tx_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        while (rng_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
        wait_drain();
        repeat (6) send_tick(1'b1);
        wait_drain();
        ranging_cycle(0, 5);
    endtask

    task automatic test_random();
        int goal;
        goal = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < goal) begin
            repeat ($urandom_range(0, 2)) write_random_reg();
            // broken sequences now and then
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
            ranging_cycle($urandom_range(0, 6),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 20));
        end
    endtask

    task automatic test_steady_flow();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (2) ranging_cycle(1, 6);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // result side, random stalls and one long hold-off
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                pop <= 1'b0;
                hold_rx = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (readings_q.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer expected none actual segments %0h",
                         $time, o_segments);
            end else begin
                head = readings_q.pop_front();
                check_field("trigger_out", head.trig, o_trigger_out);
                check_field("digit_select", head.sel, o_digit_select);
                check_field("segments", head.seg, o_segments);
                check_field("distance_cm", head.distance, o_distance_cm);
                check_field("distance_new", head.fresh, o_distance_new);
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        ranger_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_registers();
        test_extremes();
        test_rounding();
        test_unknown_index();
        test_back_pressure();
        test_drain_pause();
        test_random();
        test_steady_flow();
        wait_drain();
        if (cfg_offering) begin
            i_cfg_valid <= 1'b0;
            cfg_offering = 1'b0;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && readings_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/urs_pkg.sv
design/urs_front.sv
design/urs_queue.sv
design/urs_back.sv
design/ultrasonic_ranger_seven_segment_core.sv
tb/tb_ultrasonic_ranger_seven_segment_core.sv
